FILE: rtl/tih_pkg.sv
`timescale 1ns / 1ps

package tih_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdW   = 32;
  localparam int unsigned PosW  = 4;
  localparam int unsigned Depth = 16;

  localparam logic [IdW-1:0] GeneralMark = 32'h8000_0000;
  localparam logic [IdW-1:0] Low31Mask   = 32'h7FFF_FFFF;
  localparam logic [IdW-1:0] AlnumMark   = 32'h4000_0000;

  localparam logic [IdW-1:0] MULT_TABLE [Depth] = '{
    32'h01EE5DB9, 32'h491408C3, 32'h0465FB69, 32'h421F0141,
    32'h2E7D036B, 32'h2D41C7B9, 32'h58C0EF0D, 32'h7B15A53B,
    32'h7C9D3761, 32'h5ABB9B0B, 32'h24109367, 32'h5A5B741F,
    32'h6B9F12E9, 32'h71BA7809, 32'h081F69CD, 32'h4D9B740B
  };

  // one request as held in the input register
  typedef struct packed {
    logic [ByteW-1:0] char_byte;
    logic             byte_present;
    logic             word_end;
  } item_t;

  function automatic logic is_alnum(input logic [ByteW-1:0] b);
    return (b >= 8'h30 && b <= 8'h39) ||
           (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

FILE: rtl/tih_if.sv
`timescale 1ns / 1ps

interface tih_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_present;
  logic       word_end;

  modport source (output valid, char_byte, byte_present, word_end, input ready);
  modport sink   (input valid, char_byte, byte_present, word_end, output ready);
endinterface

interface tih_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] word_id;
  logic               alnum_form;

  modport source (output valid, word_id, alnum_form, input ready);
  modport sink   (input valid, word_id, alnum_form, output ready);
endinterface

FILE: rtl/token_id_hasher_top.sv
`timescale 1ns / 1ps
// token_id_hasher_top: hashes the bytes of a word into a 32-bit word id.
//
// in_i  : one request per byte (char_byte, byte_present, word_end). A zero
//         or absent byte is skipped; word_end closes the word after the
//         request's own byte is hashed. A word with no byte gives id 0.
// out_o : one result per word end (word_id, alnum_form).
// cfg   : cfg_we_i / cfg_wdata_i write general_only; write only while idle.
//
// Path: a request accepted on in_i is held in the input register, and its
// result is held in the result register on out_o (two register stages).
// Throughput: one request per cycle outside a Stall, set by the single
// table-multiply and 32-bit accumulate between input and result registers.
// Stall: while a result waits on out_o, requests that do not end a word keep
// flowing; the next word end holds in the input register until the result
// slot drains, and in_i.ready then follows out_o.ready.
// Reset: clears the running sum, position and seen flag, sets alnum to 1,
// drops both valid stages and sets general_only to 0.
module token_id_hasher_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  tih_in_if.sink    in_i,
  tih_out_if.source out_o
);
  import tih_pkg::*;

  logic  general_only_q;
  logic  stage_valid;
  logic  take;
  item_t stage_item;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      general_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      general_only_q <= cfg_wdata_i;
    end
  end

  // input register stage
  tih_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  // hash accumulator and result register
  tih_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .general_only_i (general_only_q),
    .valid_i        (stage_valid),
    .item_i         (stage_item),
    .take_o         (take),
    .out_o          (out_o)
  );

endmodule

FILE: rtl/tih_in_stage.sv
`timescale 1ns / 1ps

module tih_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  tih_in_if.sink        in_i,
  input  logic          take_i,
  output logic          valid_o,
  output tih_pkg::item_t item_o
);
  import tih_pkg::*;

  logic  valid_d, valid_q;
  item_t item_q;
  logic  accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.char_byte    <= in_i.char_byte;
      item_q.byte_present <= in_i.byte_present;
      item_q.word_end     <= in_i.word_end;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/tih_accum.sv
`timescale 1ns / 1ps

module tih_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           general_only_i,
  input  logic           valid_i,
  input  tih_pkg::item_t item_i,
  output logic           take_o,
  tih_out_if.source      out_o
);
  import tih_pkg::*;

  logic [IdW-1:0]       sum_d, sum_q;
  logic [PosW-1:0]      pos_d, pos_q;
  logic                 alnum_d, alnum_q;
  logic                 seen_d, seen_q;
  logic                 ovalid_d, ovalid_q;
  logic [IdW-1:0]       id_d, id_q;
  logic                 form_d, form_q;

  logic                 take;
  logic                 byte_ok;
  logic [IdW+ByteW-1:0] prod;
  logic [IdW-1:0]       sum_upd;
  logic                 alnum_upd;
  logic                 seen_upd;

  // an ending request needs the result slot free or draining
  assign take   = valid_i && (!item_i.word_end || !ovalid_q || out_o.ready);
  assign take_o = take;

  assign byte_ok   = item_i.byte_present && (item_i.char_byte != '0);
  assign prod      = MULT_TABLE[pos_q] * item_i.char_byte;
  assign sum_upd   = byte_ok ? sum_q + prod[IdW-1:0] : sum_q;
  assign alnum_upd = alnum_q && (!byte_ok || is_alnum(item_i.char_byte));
  assign seen_upd  = seen_q || byte_ok;

  always_comb begin
    sum_d    = sum_q;
    pos_d    = pos_q;
    alnum_d  = alnum_q;
    seen_d   = seen_q;
    ovalid_d = ovalid_q && !out_o.ready;
    id_d     = id_q;
    form_d   = form_q;
    if (take) begin
      if (item_i.word_end) begin
        sum_d    = '0;
        pos_d    = '0;
        alnum_d  = 1'b1;
        seen_d   = 1'b0;
        ovalid_d = 1'b1;
        if (!seen_upd) begin
          id_d   = '0;
          form_d = 1'b0;
        end else if (general_only_i || !alnum_upd) begin
          id_d   = sum_upd | GeneralMark;
          form_d = 1'b0;
        end else begin
          id_d   = (sum_upd & Low31Mask) | AlnumMark;
          form_d = 1'b1;
        end
      end else begin
        sum_d   = sum_upd;
        pos_d   = byte_ok ? pos_q + 1'b1 : pos_q;
        alnum_d = alnum_upd;
        seen_d  = seen_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      pos_q    <= '0;
      alnum_q  <= 1'b1;
      seen_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      alnum_q  <= alnum_d;
      seen_q   <= seen_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    form_q <= form_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.word_id    = $signed(id_q);
  assign out_o.alnum_form = form_q;

  a_end_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.word_end |=> ovalid_q && !seen_q && pos_q == '0 && sum_q == '0)
    else $error("word end did not load result and clear state");

  a_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> sum_q == '0 && pos_q == '0 && alnum_q)
    else $error("state dirty without any byte");

  a_alnum_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && form_q |-> id_q[IdW-1:IdW-2] == 2'b01)
    else $error("alphanumeric id lacks its tag bits");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_o.ready |=> ovalid_q && $stable(id_q) && $stable(form_q))
    else $error("pending result lost while stalled");

endmodule
